// ----- rtl/core/slb_pkg.sv -----
// Shared constants, types and a helper function of the smoothed level bargraph.
package slb_pkg;

	localparam int unsigned FIELD_W     = 10;
	localparam int unsigned WINDOW      = 15;
	localparam int unsigned FULL_SCALE  = 1023;
	localparam int unsigned RESCALE_SPAN = FULL_SCALE - 1;
	localparam int unsigned LIMIT_MIN   = 2;
	localparam int unsigned LIMIT_RESET = 15;
	localparam int unsigned BAR_BASE    = 50;
	localparam int unsigned BAR_STEP    = 100;
	localparam int unsigned BAR_COUNT   = 10;

	localparam int unsigned TOTAL_W = $clog2(WINDOW * FULL_SCALE + 1);
	localparam int unsigned POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	// Divider geometry: the quotient always fits the field width.
	localparam int unsigned QUO_W   = FIELD_W;
	localparam int unsigned DVS_W   = FIELD_W;
	localparam int unsigned DIVD_W  = QUO_W + DVS_W;
	localparam int unsigned STEP_W  = $clog2(QUO_W + 1);

	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_UPDATE,
		ST_AVG_WAIT,
		ST_OUT
	} slb_state_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [BAR_COUNT-1:0] bar_of(input logic [FIELD_W-1:0] avg);
		logic [BAR_COUNT-1:0] bits;
		bits = '0;
		for (int k = 0; k < BAR_COUNT; k++) begin
			bits[k] = (avg > FIELD_W'(BAR_BASE + BAR_STEP * k));
		end
		return bits;
	endfunction

endpackage

// ----- rtl/core/slb_div.sv -----
// Restoring divider, one quotient bit per cycle, for quotients below 2**QUO_W.
module slb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  slb_pkg::div_req_t req,
	output slb_pkg::div_rsp_t rsp
);
	import slb_pkg::*;

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DVS_W-1:0]  rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [DVS_W-1:0]  divisor_q;

	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, low_q[QUO_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= STEP_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	// The upper half of the dividend is below the divisor, so it seeds the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.dividend[DIVD_W-1:QUO_W];
			low_q     <= req.dividend[QUO_W-1:0];
			divisor_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			low_q <= {low_q[QUO_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = low_q;

endmodule

// ----- rtl/core/smoothed_level_bargraph_core.sv -----
// Top level of the smoothed level bargraph: sequencer, window ring and output register.
//
// Each accepted nonzero sample is clamped to 1..sense_limit (a limit below 2 acts
// as 2), rescaled to 1..1023, pushed into a 15-entry moving window, and one result
// item follows carrying the bargraph, the window average and the rescaled sample.
// A zero sample is taken and gives no result. A nonzero sample keeps s_tready low
// until its result is moved to the output register, which waits for a free slot;
// most of the work is one shared restoring divider, used once for the rescale and
// once for the average. The finished result sits in the output register, and the
// next sample is taken while it waits. The window and running total clear at reset.
module smoothed_level_bargraph_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [9:0] bar_segments, [19:10] window_average,
	                               // [29:20] scaled_sample
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata  // sense_limit
);
	import slb_pkg::*;

	slb_state_t state_q, state_d;

	logic [FIELD_W-1:0] sense_limit_q;
	logic [FIELD_W-1:0] sample_q;
	logic [DIVD_W-1:0]  product_q;
	logic [DVS_W-1:0]   divisor_q;
	logic [FIELD_W-1:0] scaled_q;
	logic [FIELD_W-1:0] avg_q;
	logic [FIELD_W-1:0] window_store_q [WINDOW];
	logic [TOTAL_W-1:0] total_q;
	logic [POS_W-1:0]   pos_q;
	logic               m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;

	logic               in_fire;
	logic               out_free;
	logic [FIELD_W-1:0] limit_eff;
	logic [FIELD_W-1:0] clamped;
	logic [TOTAL_W-1:0] total_next;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign limit_eff = (sense_limit_q < FIELD_W'(LIMIT_MIN)) ? FIELD_W'(LIMIT_MIN)
	                                                         : sense_limit_q;
	assign clamped   = (sample_q > limit_eff) ? limit_eff : sample_q;

	assign total_next = total_q - TOTAL_W'(window_store_q[pos_q]) + TOTAL_W'(scaled_q);

	slb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (s_tdata[FIELD_W-1:0] != '0)) state_d = ST_MUL;
			end
			ST_MUL:        state_d = ST_SCALE_GO;
			ST_SCALE_GO:   state_d = ST_SCALE_WAIT;
			ST_SCALE_WAIT: begin
				if (div_rsp.done) state_d = ST_UPDATE;
			end
			ST_UPDATE:     state_d = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (div_rsp.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = product_q;
		div_req.divisor  = divisor_q;
		unique case (state_q)
			ST_IDLE:     s_tready = 1'b1;
			ST_SCALE_GO: div_req.start = 1'b1;
			ST_UPDATE: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVD_W'(total_next);
				div_req.divisor  = DVS_W'(WINDOW);
			end
			ST_MUL, ST_SCALE_WAIT, ST_AVG_WAIT, ST_OUT: begin
				s_tready = 1'b0;
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sense_limit_q <= FIELD_W'(LIMIT_RESET);
			total_q       <= '0;
			pos_q         <= '0;
			m_valid_q     <= 1'b0;
			for (int i = 0; i < WINDOW; i++) begin
				window_store_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) sense_limit_q <= cfg_wdata;
			if (state_q == ST_UPDATE) begin
				window_store_q[pos_q] <= scaled_q;
				total_q <= total_next;
				pos_q   <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) sample_q <= s_tdata[FIELD_W-1:0];
		if (state_q == ST_MUL) begin
			product_q <= DIVD_W'(clamped - 1'b1) * DIVD_W'(RESCALE_SPAN);
			divisor_q <= limit_eff - 1'b1;
		end
		if (state_q == ST_SCALE_WAIT && div_rsp.done) scaled_q <= div_rsp.quotient + 1'b1;
		if (state_q == ST_AVG_WAIT && div_rsp.done) avg_q <= div_rsp.quotient;
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= {2'b00, scaled_q, avg_q, bar_of(avg_q)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ----- rtl/core/slb_checker.sv -----
// Port-level assertions for the smoothed level bargraph, bound to the top level.
module slb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_we,
	input logic [9:0]  cfg_wdata
);
	import slb_pkg::*;

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A nonzero sample starts the sequencer, which then takes no item.
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[9:0] != 10'd0) |=> !s_tready)
		else $error("item taken while a sample is in work");

	// The rescaled sample never maps to zero.
	a_scaled_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[29:20] != 10'd0))
		else $error("scaled sample is zero");

	// The bargraph agrees with the average it comes with.
	a_bar_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:0] == bar_of(m_tdata[19:10])))
		else $error("bargraph does not match average");

	// Unused parts of the ports carry nothing that matters here.
	logic unused_ok;
	assign unused_ok = cfg_we ^ (^cfg_wdata) ^ (^s_tdata[15:10]) ^ (^m_tdata[31:30]);

endmodule

bind smoothed_level_bargraph_core slb_checker u_slb_checker (.*);
